// ===== hw/rtl/msd_pkg.sv =====
// ---------------------------------------------------------------------------
// msd_pkg: shared types and constants for the motor stall detector
// Holds request/result structs, register indexes, direction codes and the
// helper that maps a signed speed onto a direction.
// ---------------------------------------------------------------------------
package msd_pkg;

	// Request kinds
	localparam logic OP_SET_SPEED = 1'b0;
	localparam logic OP_CHECK     = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_MIN_MOVE = 2'd0;
	localparam logic [1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_CHANNEL  = 2'd2;

	// Driver channels that actually take drive writes
	localparam logic [1:0] CH_A = 2'd1;
	localparam logic [1:0] CH_B = 2'd2;

	// Reset values of the configuration registers
	localparam logic [15:0] MIN_MOVE_RST = 16'd10;
	localparam logic [15:0] TIMEOUT_RST  = 16'd500;
	localparam logic [1:0]  CHANNEL_RST  = 2'd1;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	typedef struct packed {
		logic [15:0] min_move;
		logic [15:0] timeout;
		logic [1:0]  channel;
	} cfg_t;

	typedef struct packed {
		logic               operation;
		logic signed [15:0] speed;
		logic signed [31:0] position;
		logic [31:0]        now_ms;
	} item_t;

	typedef struct packed {
		logic               drive_write;
		logic [1:0]         drive_channel;
		logic signed [15:0] drive_speed;
		logic               stall_event;
		logic               stalled;
		logic signed [15:0] commanded_speed;
	} res_t;

	// Direction of a signed speed
	function automatic dir_t dir_of(input logic signed [15:0] s);
		dir_t d;
		priority if (s > 16'sd0) d = DIR_FWD;
		else if (s < 16'sd0) d = DIR_REV;
		else d = DIR_NONE;
		return d;
	endfunction

endpackage

// ===== hw/rtl/msd_cfg.sv =====
// ---------------------------------------------------------------------------
// msd_cfg: configuration register file
// Three writable registers; writes to an unused index are dropped.
// ---------------------------------------------------------------------------
module msd_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	output msd_pkg::cfg_t cfg
);
	import msd_pkg::*;

	cfg_t cfg_q;

	// always able to take a write
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_move <= MIN_MOVE_RST;
			cfg_q.timeout  <= TIMEOUT_RST;
			cfg_q.channel  <= CHANNEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_MOVE: cfg_q.min_move <= cfg_data;
				REG_TIMEOUT:  cfg_q.timeout  <= cfg_data;
				REG_CHANNEL:  cfg_q.channel  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/msd_core.sv =====
// ---------------------------------------------------------------------------
// msd_core: stall window state and per-request decision
// Evaluates one request against the window state combinationally and
// commits the new state when the request moves on to the result register.
// ---------------------------------------------------------------------------
module msd_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  msd_pkg::item_t item,
	input  msd_pkg::cfg_t  cfg,
	output msd_pkg::res_t  res
);
	import msd_pkg::*;

	logic signed [15:0] target_q,  target_d;
	logic signed [31:0] wpos_q,    wpos_d;
	logic [31:0]        wtime_q,   wtime_d;
	logic               latch_q,   latch_d;
	dir_t               sdir_q,    sdir_d;

	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic [31:0]        elapsed;
	logic               moved;
	logic               timed_out;
	dir_t               req_dir;
	dir_t               cur_dir;
	logic               reversed;
	logic               wr;
	logic signed [15:0] drive;
	logic               event_d;
	logic               ch_ok;

	// movement over 33 bits, elapsed time modulo 2^32
	assign diff      = 33'(item.position) - 33'(wpos_q);
	assign mag       = diff[32] ? 33'(-diff) : 33'(diff);
	assign moved     = mag >= {17'd0, cfg.min_move};
	assign elapsed   = item.now_ms - wtime_q;
	assign timed_out = elapsed >= {16'd0, cfg.timeout};

	assign req_dir  = dir_of(item.speed);
	assign cur_dir  = dir_of(target_q);
	assign reversed = (cur_dir != DIR_NONE) && (req_dir != DIR_NONE) && (cur_dir != req_dir);

	// next state and drive decision
	always_comb begin
		target_d = target_q;
		wpos_d   = wpos_q;
		wtime_d  = wtime_q;
		latch_d  = latch_q;
		sdir_d   = sdir_q;
		wr       = 1'b0;
		drive    = 16'sd0;
		event_d  = 1'b0;
		if (item.operation == OP_SET_SPEED) begin
			wr = 1'b1;
			if (latch_q && (req_dir != DIR_NONE) && (req_dir == sdir_q)) begin
				// command into the stalled direction: drive zero only
				drive = 16'sd0;
			end else begin
				target_d = item.speed;
				drive    = item.speed;
				if ((item.speed == 16'sd0) || (target_q == 16'sd0) || reversed) begin
					wpos_d  = item.position;
					wtime_d = item.now_ms;
					latch_d = 1'b0;
					sdir_d  = DIR_NONE;
				end
			end
		end else begin
			priority if ((target_q == 16'sd0) || moved) begin
				wpos_d  = item.position;
				wtime_d = item.now_ms;
				latch_d = 1'b0;
				sdir_d  = DIR_NONE;
			end else if (latch_q) begin
				wr = 1'b1;
			end else if (timed_out) begin
				latch_d  = 1'b1;
				sdir_d   = cur_dir;
				target_d = 16'sd0;
				wr       = 1'b1;
				event_d  = 1'b1;
			end else begin
				wr = 1'b0;
			end
		end
	end

	// only channels A and B are driven
	assign ch_ok = (cfg.channel == CH_A) || (cfg.channel == CH_B);

	always_comb begin
		res.drive_write     = wr && ch_ok;
		res.drive_channel   = (wr && ch_ok) ? cfg.channel : 2'd0;
		res.drive_speed     = (wr && ch_ok) ? drive : 16'sd0;
		res.stall_event     = event_d;
		res.stalled         = latch_d;
		res.commanded_speed = target_d;
	end

	// state commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 16'sd0;
			wpos_q   <= 32'sd0;
			wtime_q  <= 32'd0;
			latch_q  <= 1'b0;
			sdir_q   <= DIR_NONE;
		end else if (step) begin
			target_q <= target_d;
			wpos_q   <= wpos_d;
			wtime_q  <= wtime_d;
			latch_q  <= latch_d;
			sdir_q   <= sdir_d;
		end
	end

`ifndef SYNTHESIS
	// a latched stall always records a direction
	a_latch_has_dir: assert property (@(posedge clk) disable iff (!arst_n)
		latch_q |-> (sdir_q == DIR_FWD) || (sdir_q == DIR_REV))
		else $error("stall latched without a direction");

	// a stall clears the stored target
	a_stall_clears_target: assert property (@(posedge clk) disable iff (!arst_n)
		step && event_d |=> (target_q == 16'sd0) && latch_q)
		else $error("stall did not clear target");
`endif

endmodule

// ===== hw/rtl/motor_stall_detector_unit.sv =====
// ---------------------------------------------------------------------------
// motor_stall_detector_unit: motor stall detector top level
// Input register, combinational decision stage and result register.
// ---------------------------------------------------------------------------
// Every request (speed command or safety check) gives exactly one result.
// A request is registered on entry and its result is then captured in the output
// register that drives out_valid. One request per cycle is sustained while the
// output is not stalled: the window state is read and updated in the same cycle
// as the decision, so back-to-back requests see each other's effect.
// Configuration writes are taken every cycle and should only be made while no
// request is in flight.
module motor_stall_detector_unit (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// requests
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic signed [15:0] speed,
	input  logic signed [31:0] position,
	input  logic [31:0]        now_ms,
	// results
	output logic               out_valid,
	input  logic               out_stall,
	output logic               drive_write,
	output logic [1:0]         drive_channel,
	output logic signed [15:0] drive_speed,
	output logic               stall_event,
	output logic               stalled,
	output logic signed [15:0] commanded_speed
);
	import msd_pkg::*;

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1;
	res_t  res_c;
	res_t  res_q;
	logic  out_valid_q;
	logic  out_free;
	logic  step;
	logic  in_take;

	msd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// flow control
	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.operation <= operation;
			item_s1.speed     <= speed;
			item_s1.position  <= position;
			item_s1.now_ms    <= now_ms;
		end
	end

	msd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_c;
		end
	end

	assign out_valid       = out_valid_q;
	assign drive_write     = res_q.drive_write;
	assign drive_channel   = res_q.drive_channel;
	assign drive_speed     = res_q.drive_speed;
	assign stall_event     = res_q.stall_event;
	assign stalled         = res_q.stalled;
	assign commanded_speed = res_q.commanded_speed;

`ifndef SYNTHESIS
	// a new stall is reported with the latch set and zero drive
	a_event_latched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stall_event |-> stalled && (drive_speed == 16'sd0)
			&& (commanded_speed == 16'sd0))
		else $error("stall event without latch or with nonzero drive");

	// drive writes only go to a real channel
	a_write_channel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_write |-> (drive_channel == CH_A) || (drive_channel == CH_B))
		else $error("drive write on an undriven channel");

	// no write means quiet drive fields
	a_no_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_write |-> (drive_channel == 2'd0) && (drive_speed == 16'sd0))
		else $error("drive fields set without a write");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench for the motor stall detector
// Drives speed commands and safety checks through the request channel, keeps
// its own model of the stall window, latch and stored target, and compares
// every result field with that model. The run covers directed corner cases,
// extreme register settings, random motion profiles under varying idling,
// and a long output hold-off that fills the block.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import msd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned REPORT_LIMIT = 10;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               operation = 1'b0;
	logic signed [15:0] speed = '0;
	logic signed [31:0] position = '0;
	logic [31:0]        now_ms = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               drive_write;
	logic [1:0]         drive_channel;
	logic signed [15:0] drive_speed;
	logic               stall_event;
	logic               stalled;
	logic signed [15:0] commanded_speed;

	motor_stall_detector_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.speed           (speed),
		.position        (position),
		.now_ms          (now_ms),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.drive_write     (drive_write),
		.drive_channel   (drive_channel),
		.drive_speed     (drive_speed),
		.stall_event     (stall_event),
		.stalled         (stalled),
		.commanded_speed (commanded_speed)
	);

	// Shadow registers and detector state
	logic [15:0]        mm_cfg = MIN_MOVE_RST;
	logic [15:0]        to_cfg = TIMEOUT_RST;
	logic [1:0]         ch_cfg = CHANNEL_RST;
	logic signed [15:0] tgt_speed = '0;
	logic signed [31:0] win_pos = '0;
	logic [31:0]        win_time = '0;
	logic               latched = 1'b0;
	dir_t               latched_dir = DIR_NONE;

	// Status results still owed by the block, oldest first
	res_t status_due [$];

	// Simulated motor timeline for random traffic
	logic signed [31:0] sim_pos = '0;
	logic [31:0]        sim_time = 32'hFFFF_0000;

	int unsigned send_gap_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	int unsigned errors = 0;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_stalls = 0;
	int unsigned n_drives = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic dir_t heading(input logic signed [15:0] s);
		return (s == 0) ? DIR_NONE : (s[15] ? DIR_REV : DIR_FWD);
	endfunction

	function automatic void restart_window(input logic signed [31:0] pos, input logic [31:0] t);
		win_pos = pos;
		win_time = t;
		latched = 1'b0;
		latched_dir = DIR_NONE;
	endfunction

	// Advance the detector by one request and return its status
	function automatic res_t track_motor(input logic op, input logic signed [15:0] spd,
		input logic signed [31:0] pos, input logic [31:0] t);
		res_t r;
		dir_t want;
		dir_t have;
		longint dpos;
		longint mag;
		logic [31:0] elapsed;
		logic wr;
		logic signed [15:0] drv;
		r = '0;
		wr = 1'b0;
		drv = '0;
		if (op == OP_SET_SPEED) begin
			want = heading(spd);
			have = heading(tgt_speed);
			if (latched && want != DIR_NONE && want == latched_dir) begin
				// command towards the stall is refused
				wr = 1'b1;
			end else begin
				if (spd == 0 || have == DIR_NONE || (want != DIR_NONE && have != want))
					restart_window(pos, t);
				tgt_speed = spd;
				wr = 1'b1;
				drv = spd;
			end
		end else begin
			// 33-bit distance, never wraps
			dpos = longint'(pos) - longint'(win_pos);
			mag = (dpos < 0) ? -dpos : dpos;
			elapsed = t - win_time;
			if (tgt_speed == 0) begin
				restart_window(pos, t);
			end else if (mag >= longint'(mm_cfg)) begin
				restart_window(pos, t);
			end else if (latched) begin
				wr = 1'b1;
			end else if (elapsed >= {16'd0, to_cfg}) begin
				latched = 1'b1;
				latched_dir = heading(tgt_speed);
				tgt_speed = '0;
				wr = 1'b1;
				r.stall_event = 1'b1;
			end
		end
		if (wr && (ch_cfg == CH_A || ch_cfg == CH_B)) begin
			r.drive_write = 1'b1;
			r.drive_channel = ch_cfg;
			r.drive_speed = drv;
		end
		r.stalled = latched;
		r.commanded_speed = tgt_speed;
		return r;
	endfunction

	// Offer one request, with random idle cycles first
	task automatic send_req(input logic op, input logic signed [15:0] spd,
		input logic signed [31:0] pos, input logic [31:0] t);
		res_t r;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		speed <= spd;
		position <= pos;
		now_ms <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
		r = track_motor(op, spd, pos, t);
		status_due.push_back(r);
		n_sent++;
		if (r.stall_event) n_stalls++;
		if (r.drive_write) n_drives++;
	endtask

	// Mostly plausible motion, some pure noise
	task automatic send_random();
		logic op;
		logic signed [15:0] spd;
		int unsigned dt;
		int dp;
		if ($urandom_range(99) < 8) begin
			send_req(1'($urandom), 16'($urandom), 32'($urandom), $urandom);
			return;
		end
		op = ($urandom_range(99) < 35) ? OP_SET_SPEED : OP_CHECK;
		case ($urandom_range(7))
			0: spd = '0;
			1: spd = 16'sh7FFF;
			2: spd = 16'sh8000;
			3: spd = 16'($urandom);
			default: begin
				spd = 16'($urandom_range(1, 3000));
				if ($urandom_range(1)) spd = -spd;
			end
		endcase
		if ($urandom_range(19) == 0) dt = $urandom;
		else dt = $urandom_range(0, 2 * to_cfg + 2);
		// either creeping below the threshold or clearly turning
		if ($urandom_range(1)) dp = (mm_cfg == 0) ? 0 : $urandom_range(0, mm_cfg - 1);
		else dp = mm_cfg + $urandom_range(0, 100);
		if ($urandom_range(1)) dp = -dp;
		sim_time += dt;
		sim_pos += dp;
		send_req(op, spd, sim_pos, sim_time);
	endtask

	// Stop offering and wait for every owed result
	task automatic settle();
		in_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Program all three registers back to back; block must be idle
	task automatic write_regs(input logic [15:0] move, input logic [15:0] wait_ms,
		input logic [1:0] chan);
		logic [1:0] idx [3];
		logic [15:0] val [3];
		idx = '{REG_MIN_MOVE, REG_TIMEOUT, REG_CHANNEL};
		val = '{move, wait_ms, {14'd0, chan}};
		foreach (idx[i]) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (cfg_ready !== 1'b1);
		end
		cfg_valid <= 1'b0;
		mm_cfg = move;
		to_cfg = wait_ms;
		ch_cfg = chan;
	endtask

	// Corner cases at reset register values
	task automatic test_directed();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		send_req(OP_CHECK, 16'sh1234, 32'sd0, 32'd0);             // zero target
		send_req(OP_SET_SPEED, 16'sh7FFF, 32'sd0, 32'd10);        // start from rest
		send_req(OP_CHECK, 16'sd0, 32'sd5, 32'd100);
		send_req(OP_CHECK, 16'sd0, 32'sd9, 32'd509);              // one ms short
		send_req(OP_CHECK, 16'sd0, 32'sd9, 32'd510);              // stall forward
		send_req(OP_SET_SPEED, 16'sd100, 32'sd9, 32'd520);        // refused
		send_req(OP_SET_SPEED, 16'sh7FFF, 32'sd9, 32'd525);       // refused
		send_req(OP_SET_SPEED, 16'sh8000, 32'sh8000_0000, 32'd530);
		send_req(OP_CHECK, 16'shFFFF, 32'sh7FFF_FFFF, 32'd540);   // widest distance
		send_req(OP_SET_SPEED, 16'sd5, 32'sh7FFF_FFFF, 32'd550);  // reversal
		send_req(OP_SET_SPEED, 16'sd7, 32'sd100, 32'd560);        // same direction
		send_req(OP_CHECK, 16'sd0, 32'sd2147483640, 32'd600);
		send_req(OP_SET_SPEED, -16'sd7, 32'sd0, 32'hFFFF_FF00);
		send_req(OP_CHECK, 16'sd0, -32'sd9, 32'h0000_00F3);        // elapsed across wrap
		send_req(OP_CHECK, 16'sd0, -32'sd9, 32'h0000_00F4);        // stall reverse
		send_req(OP_SET_SPEED, -16'sd1, 32'sd0, 32'h0000_0100);   // refused
		send_req(OP_SET_SPEED, 16'sd0, 32'sd0, 32'hFFFF_FFFF);    // zero speed
		send_req(OP_CHECK, 16'sd0, 32'sh0000_7FFF, 32'hFFFF_FFFF);
		send_req(OP_SET_SPEED, 16'sd1, 32'sd0, 32'd0);
		send_req(OP_CHECK, 16'sd0, 32'sd10, 32'd1);               // exactly the threshold
		send_req(OP_CHECK, 16'sd0, 32'sd0, 32'd501);
		send_req(OP_CHECK, 16'sd0, 32'sd0, 32'd1001);             // exactly the timeout
		settle();
	endtask

	// Extreme register values, including the channels that never drive
	task automatic test_register_extremes();
		logic [15:0] moves [4] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0};
		logic [15:0] waits [4] = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
		logic [1:0]  chans [4] = '{2'd0, 2'd3, CH_B, CH_A};
		send_gap_pct = 20;
		recv_stall_pct = 20;
		foreach (moves[i]) begin
			write_regs(moves[i], waits[i], chans[i]);
			send_req(OP_SET_SPEED, 16'sd300, sim_pos, sim_time);
			send_req(OP_CHECK, 16'sd0, sim_pos, sim_time);
			send_req(OP_CHECK, 16'sd0, sim_pos + 32'sd65535, sim_time + 32'd65535);
			sim_pos += 32'sd65535;
			sim_time += 32'd65535;
			repeat (30) send_random();
			settle();
		end
	endtask

	// Random motion under three idling patterns
	task automatic test_random_traffic();
		int unsigned gaps [3] = '{10, 87, 0};
		int unsigned stalls [3] = '{87, 10, 0};
		foreach (gaps[p]) begin
			write_regs(16'($urandom_range(0, 300)), 16'($urandom_range(0, 1500)),
				2'($urandom_range(CH_A, CH_B)));
			send_gap_pct = gaps[p];
			recv_stall_pct = stalls[p];
			repeat (480) send_random();
			settle();
		end
	endtask

	// Long output hold-off fills the block, then a full drain mid-stream
	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_left = 300;
		repeat (40) send_random();
		settle();
		recv_stall_pct = 30;
		repeat (40) send_random();
		settle();
	endtask

	// Result checking and output stall generation
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (status_due.size() == 0) begin
				if (errors < REPORT_LIMIT)
					$display("unexpected result at cycle %0d", cycle_count);
				errors++;
			end else begin
				want = status_due.pop_front();
				n_checked++;
				if (drive_write !== want.drive_write || drive_channel !== want.drive_channel ||
					drive_speed !== want.drive_speed || stall_event !== want.stall_event ||
					stalled !== want.stalled || commanded_speed !== want.commanded_speed) begin
					if (errors < REPORT_LIMIT)
						$display("mismatch at cycle %0d: exp wr=%0b ch=%0d drv=%0d ev=%0b st=%0b cmd=%0d | got wr=%0b ch=%0d drv=%0d ev=%0b st=%0b cmd=%0d",
							cycle_count, want.drive_write, want.drive_channel,
							want.drive_speed, want.stall_event, want.stalled,
							want.commanded_speed, drive_write, drive_channel, drive_speed,
							stall_event, stalled, commanded_speed);
					errors++;
				end
			end
		end
		cycle_count++;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", cycle_count);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_traffic();
		test_backpressure();
		$display("%0d requests sent, %0d results checked, %0d stalls declared, %0d drive writes",
			n_sent, n_checked, n_stalls, n_drives);
		$display("covered reset and extreme register values, time wrap, idling and hold-off");
		if (errors == 0 && status_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
